// File: hdl/awvn_pkg.sv
package awvn_pkg;

    // Field widths of the item and result ports.
    localparam int IDX_W  = 12;
    localparam int POS_W  = 32;
    localparam int NRM_W  = 18;
    localparam int AREA_W = 48;

    // Internal datapath widths.
    localparam int CRS_W  = 49;   // cross product component, signed Q32.16
    localparam int MUL_W  = 33;   // shared multiplier operand, signed
    localparam int PROD_W = 66;   // shared multiplier product, signed
    localparam int NUM_W  = 51;   // blend numerator, signed
    localparam int DVD_W  = 50;   // divider dividend magnitude
    localparam int DEN_W  = 33;   // divider divisor
    localparam int QUO_W  = 18;   // divider quotient, never above one in Q1.16
    localparam int TOT_W  = 49;   // old area plus face area
    localparam int SQ_W   = 64;   // square root radicand
    localparam int ROOT_W = 32;   // square root result

    localparam logic [QUO_W-1:0]  NORM_ONE = 18'd65536;
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    // Operation codes on the item port.
    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_TRIANGLE = 2'd1,
        OP_READ     = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    // Work kinds after the front end has checked the indices.
    typedef enum logic [1:0] {
        K_WRITE,
        K_TRI,
        K_READ,
        K_READ_ZERO
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         index_a;
        logic [IDX_W-1:0]         index_b;
        logic [IDX_W-1:0]         index_c;
        logic signed [POS_W-1:0]  coord_x;
        logic signed [POS_W-1:0]  coord_y;
        logic signed [POS_W-1:0]  coord_z;
    } t_cmd;

endpackage

// File: hdl/awvn_div.sv
module awvn_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [awvn_pkg::DVD_W-1:0]  i_dividend,
    input  logic [awvn_pkg::DEN_W-1:0]  i_divisor,
    output logic [awvn_pkg::QUO_W-1:0]  o_quotient,
    output logic                        o_done
);
    import awvn_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DVD_W-1:0] r_rem;
    logic [DVD_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             take;

    // One quotient bit per cycle, most significant first.
    assign take = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Remainder, shifted divisor and quotient carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_den <= {i_divisor, {(QUO_W-1){1'b0}}};
            r_quo <= '0;
        end else if (r_busy) begin
            if (take) begin
                r_rem <= r_rem - r_den;
            end
            r_quo <= {r_quo[QUO_W-2:0], take};
            r_den <= r_den >> 1;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// File: hdl/awvn_sqrt.sv
module awvn_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [awvn_pkg::SQ_W-1:0]    i_value,
    output logic [awvn_pkg::ROOT_W-1:0]  o_root,
    output logic                         o_done
);
    import awvn_pkg::*;

    logic [SQ_W-1:0] r_n;
    logic [SQ_W-1:0] r_res;
    logic [SQ_W-1:0] r_bit;
    logic            r_busy;
    logic            r_done;
    logic [SQ_W-1:0] trial;

    assign trial = r_res + r_bit;

    // The step bit walks down two places a cycle, from bit 62 down to bit 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Remainder and partial root.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_value;
            r_res <= '0;
            r_bit <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[ROOT_W-1:0];
    assign o_done = r_done;

endmodule

// File: hdl/awvn_front.sv
module awvn_front #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [1:0]                         i_operation,
    input  logic [awvn_pkg::IDX_W-1:0]         i_index_a,
    input  logic [awvn_pkg::IDX_W-1:0]         i_index_b,
    input  logic [awvn_pkg::IDX_W-1:0]         i_index_c,
    input  logic signed [awvn_pkg::POS_W-1:0]  i_coord_x,
    input  logic signed [awvn_pkg::POS_W-1:0]  i_coord_y,
    input  logic signed [awvn_pkg::POS_W-1:0]  i_coord_z,
    input  logic                               i_clearing,
    input  logic                               i_take,
    output awvn_pkg::t_cmd                     o_cmd,
    output logic                               o_cmd_valid
);
    import awvn_pkg::*;

    localparam int QD = 4;
    localparam int QA = $clog2(QD);

    t_cmd            r_q [QD];
    logic [QA-1:0]   r_wp;
    logic [QA-1:0]   r_rp;
    logic [QA:0]     r_cnt;
    logic            ok_a;
    logic            ok_b;
    logic            ok_c;
    logic            keep;
    t_kind           kind;
    logic            enq;
    logic            deq;
    t_cmd            cmd_in;

    // Range check of the indices against the table depth.
    assign ok_a = (32'(i_index_a) < 32'(MAX_VERTICES));
    assign ok_b = (32'(i_index_b) < 32'(MAX_VERTICES));
    assign ok_c = (32'(i_index_c) < 32'(MAX_VERTICES));

    // Classify the item; items with no effect are accepted and dropped.
    always_comb begin
        keep = 1'b0;
        kind = K_WRITE;
        case (t_op'(i_operation))
            OP_WRITE: begin
                keep = ok_a;
                kind = K_WRITE;
            end
            OP_TRIANGLE: begin
                keep = ok_a && ok_b && ok_c;
                kind = K_TRI;
            end
            OP_READ: begin
                keep = 1'b1;
                kind = ok_a ? K_READ : K_READ_ZERO;
            end
            OP_NONE: begin
                keep = 1'b0;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        cmd_in.kind    = kind;
        cmd_in.index_a = i_index_a;
        cmd_in.index_b = i_index_b;
        cmd_in.index_c = i_index_c;
        cmd_in.coord_x = i_coord_x;
        cmd_in.coord_y = i_coord_y;
        cmd_in.coord_z = i_coord_z;
    end

    assign full        = (r_cnt == (QA+1)'(QD)) || i_clearing;
    assign enq         = push && !full && keep;
    assign deq         = i_take && o_cmd_valid;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (deq) begin
                r_rp <= r_rp + 1'b1;
            end
            if (enq && !deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!enq && deq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// File: hdl/awvn_back.sv
module awvn_back #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  awvn_pkg::t_cmd                      i_cmd,
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_take,
    output logic                                o_clearing,
    input  logic                                i_pop,
    output logic                                o_out_valid,
    output logic signed [awvn_pkg::NRM_W-1:0]   o_normal_x,
    output logic signed [awvn_pkg::NRM_W-1:0]   o_normal_y,
    output logic signed [awvn_pkg::NRM_W-1:0]   o_normal_z,
    output logic [awvn_pkg::AREA_W-1:0]         o_total_area
);
    import awvn_pkg::*;

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int PM_W  = 3 * POS_W;
    localparam int NM_W  = 3 * NRM_W + AREA_W;
    localparam int AF_W  = ROOT_W + 19;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RD_WAIT, S_RD_OUT,
        S_PA, S_PB, S_PC, S_EDGE, S_CROSS, S_MAG, S_NORM, S_SQ,
        S_SQRT_GO, S_SQRT_WAIT, S_AREA, S_FDIV_WAIT,
        S_V_ISSUE, S_V_LOAD, S_V_SHIFT, S_V_MUL, S_V_DIV_GO, S_V_DIV_WAIT
    } t_state;

    // Position table and normal/area table.
    logic [PM_W-1:0] pos_mem [MAX_VERTICES];
    logic [NM_W-1:0] nm_mem  [MAX_VERTICES];

    t_state                    r_state;
    logic [AW-1:0]             r_clr;
    logic [2:0]                r_k;
    logic [1:0]                r_vj;
    logic [4:0]                r_s;
    logic                      r_rd_zero;
    logic                      r_out_valid;

    logic [AW-1:0]             r_ia;
    logic [AW-1:0]             r_ib;
    logic [AW-1:0]             r_ic;
    logic [AW-1:0]             r_vaddr;
    logic [PM_W-1:0]           r_pq;
    logic [NM_W-1:0]           r_nq;
    logic [PM_W-1:0]           r_pa;
    logic [PM_W-1:0]           r_pb;
    logic signed [POS_W-1:0]   r_e0 [3];
    logic signed [POS_W-1:0]   r_e1 [3];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [CRS_W-1:0]   r_c [3];
    logic [CRS_W-1:0]          r_mag [3];
    logic [CRS_W-1:0]          r_m;
    logic [SQ_W-1:0]           r_sum;
    logic [ROOT_W-1:0]         r_root;
    logic [AREA_W-1:0]         r_area;
    logic signed [NRM_W-1:0]   r_fn [3];
    logic signed [NRM_W-1:0]   r_on [3];
    logic [TOT_W-1:0]          r_tot;
    logic [TOT_W-1:0]          r_wo;
    logic [TOT_W-1:0]          r_wf;
    logic [AREA_W-1:0]         r_new_area;
    logic signed [NUM_W-1:0]   r_num [3];
    logic signed [NRM_W-1:0]   r_out_nx;
    logic signed [NRM_W-1:0]   r_out_ny;
    logic signed [NRM_W-1:0]   r_out_nz;
    logic [AREA_W-1:0]         r_out_area;

    logic [AW-1:0]             cmd_a;
    logic                      pos_we;
    logic [PM_W-1:0]           pos_wd;
    logic [AW-1:0]             pos_ra;
    logic                      nm_we;
    logic [AW-1:0]             nm_wa;
    logic [NM_W-1:0]           nm_wd;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic [2:0]                km1;
    logic [1:0]                jm;
    logic signed [CRS_W-1:0]   cross_term;
    logic signed [NUM_W-1:0]   blend_term;
    logic [CRS_W-1:0]          mag_now [3];
    logic [CRS_W-1:0]          max_now;
    logic [AF_W-1:0]           area_full;
    logic [AREA_W-1:0]         area_sat;
    logic [AREA_W-1:0]         old_area;
    logic [TOT_W-1:0]          tot_now;
    logic                      div_start;
    logic [DVD_W-1:0]          div_dvd [3];
    logic [DEN_W-1:0]          div_den;
    logic [QUO_W-1:0]          div_q [3];
    logic [2:0]                div_done;
    logic signed [NRM_W-1:0]   blend_n [3];
    logic                      sqrt_start;
    logic [ROOT_W-1:0]         sqrt_root;
    logic                      sqrt_done;

    function automatic logic signed [POS_W-1:0] sat_sub(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        logic signed [POS_W:0] d;
        d = (POS_W+1)'(a) - (POS_W+1)'(b);
        if (d[POS_W] != d[POS_W-1]) begin
            sat_sub = d[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            sat_sub = d[POS_W-1:0];
        end
    endfunction

    // Quotient magnitude with a sign, held to plus or minus one.
    function automatic logic signed [NRM_W-1:0] signed_norm(
        input logic [QUO_W-1:0] q,
        input logic             neg
    );
        logic [QUO_W-1:0] qc;
        qc = (q > NORM_ONE) ? NORM_ONE : q;
        signed_norm = neg ? -$signed(NRM_W'(qc)) : $signed(NRM_W'(qc));
    endfunction

    assign cmd_a       = AW'(i_cmd.index_a);
    assign o_cmd_take  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_normal_x  = r_out_nx;
    assign o_normal_y  = r_out_ny;
    assign o_normal_z  = r_out_nz;
    assign o_total_area = r_out_area;

    // Table write and read addresses.
    assign pos_we = o_cmd_take && (i_cmd.kind == K_WRITE);
    assign pos_wd = {i_cmd.coord_x, i_cmd.coord_y, i_cmd.coord_z};

    always_comb begin
        case (r_state)
            S_PA:    pos_ra = r_ia;
            S_PB:    pos_ra = r_ib;
            default: pos_ra = r_ic;
        endcase
    end

    always_comb begin
        nm_we = 1'b0;
        nm_wa = r_vaddr;
        nm_wd = '0;
        case (r_state)
            S_CLEAR: begin
                nm_we = 1'b1;
                nm_wa = r_clr;
            end
            S_IDLE: begin
                nm_we = pos_we;
                nm_wa = cmd_a;
            end
            S_V_DIV_WAIT: begin
                nm_we = div_done[0];
                nm_wd = {blend_n[0], blend_n[1], blend_n[2], r_new_area};
            end
            default: begin
                nm_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[cmd_a] <= pos_wd;
        end
        r_pq <= pos_mem[pos_ra];
    end

    always_ff @(posedge i_clk) begin
        if (nm_we) begin
            nm_mem[nm_wa] <= nm_wd;
        end
        r_nq <= nm_mem[r_vaddr];
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_CROSS: begin
                case (r_k)
                    3'd0: begin mul_a = MUL_W'(r_e0[1]); mul_b = MUL_W'(r_e1[2]); end
                    3'd1: begin mul_a = MUL_W'(r_e0[2]); mul_b = MUL_W'(r_e1[1]); end
                    3'd2: begin mul_a = MUL_W'(r_e0[2]); mul_b = MUL_W'(r_e1[0]); end
                    3'd3: begin mul_a = MUL_W'(r_e0[0]); mul_b = MUL_W'(r_e1[2]); end
                    3'd4: begin mul_a = MUL_W'(r_e0[0]); mul_b = MUL_W'(r_e1[1]); end
                    3'd5: begin mul_a = MUL_W'(r_e0[1]); mul_b = MUL_W'(r_e1[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_SQ: begin
                if (r_k < 3'd3) begin
                    mul_a = MUL_W'(r_mag[r_k[1:0]][30:0]);
                    mul_b = MUL_W'(r_mag[r_k[1:0]][30:0]);
                end
            end
            S_V_MUL: begin
                if (r_k < 3'd6) begin
                    if (r_k[0]) begin
                        mul_a = MUL_W'(r_fn[r_k[2:1]]);
                        mul_b = MUL_W'(r_wf[31:0]);
                    end else begin
                        mul_a = MUL_W'(r_on[r_k[2:1]]);
                        mul_b = MUL_W'(r_wo[31:0]);
                    end
                end
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // Product that the previous cycle formed, and where it goes.
    assign km1        = r_k - 3'd1;
    assign jm         = km1[2:1];
    assign cross_term = r_prod[CRS_W+15:16];
    assign blend_term = r_prod[NUM_W-1:0];

    // Component magnitudes and their largest.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_now[i] = r_c[i][CRS_W-1] ? CRS_W'(-r_c[i]) : CRS_W'(r_c[i]);
        end
        max_now = mag_now[0];
        if (mag_now[1] > max_now) begin
            max_now = mag_now[1];
        end
        if (mag_now[2] > max_now) begin
            max_now = mag_now[2];
        end
    end

    // Face area from the root, scaled back and halved.
    assign area_full = (AF_W'(r_root) << r_s) >> 1;
    assign area_sat  = (|area_full[AF_W-1:AREA_W]) ? AREA_MAX : area_full[AREA_W-1:0];
    assign old_area  = r_nq[AREA_W-1:0];
    assign tot_now   = TOT_W'(old_area) + TOT_W'(r_area);

    // Three dividers work on x, y and z side by side.
    assign div_start = ((r_state == S_AREA) && (r_root != '0) && (area_sat != '0))
                       || (r_state == S_V_DIV_GO);
    assign div_den   = (r_state == S_AREA) ? DEN_W'(r_root)
                                           : DEN_W'(r_wo[31:0]) + DEN_W'(r_wf[31:0]);

    generate
        for (genvar g = 0; g < 3; g++) begin : g_div
            assign div_dvd[g] = (r_state == S_AREA) ? DVD_W'({r_mag[g][30:0], 16'b0})
                : (r_num[g][NUM_W-1] ? DVD_W'(-r_num[g]) : DVD_W'(r_num[g]));
            assign blend_n[g] = signed_norm(div_q[g], r_num[g][NUM_W-1]);

            awvn_div u_div (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_start    (div_start),
                .i_dividend (div_dvd[g]),
                .i_divisor  (div_den),
                .o_quotient (div_q[g]),
                .o_done     (div_done[g])
            );
        end
    endgenerate

    assign sqrt_start = (r_state == S_SQRT_GO);

    awvn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (r_sum),
        .o_root  (sqrt_root),
        .o_done  (sqrt_done)
    );

    // Sequencer: clearing pass, then one item at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_k         <= '0;
            r_vj        <= '0;
            r_s         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A popped result is dropped here unless a read replaces it below.
            if (i_pop && r_out_valid && (r_state != S_RD_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_clr == AW'(MAX_VERTICES - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_ia    <= cmd_a;
                        r_ib    <= AW'(i_cmd.index_b);
                        r_ic    <= AW'(i_cmd.index_c);
                        r_vaddr <= cmd_a;
                        case (i_cmd.kind)
                            K_WRITE: begin
                                r_state <= S_IDLE;
                            end
                            K_TRI: begin
                                r_state <= S_PA;
                            end
                            K_READ: begin
                                r_rd_zero <= 1'b0;
                                r_state   <= S_RD_WAIT;
                            end
                            K_READ_ZERO: begin
                                r_rd_zero <= 1'b1;
                                r_state   <= S_RD_WAIT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    r_state <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    if (!r_out_valid || i_pop) begin
                        r_out_valid <= 1'b1;
                        if (r_rd_zero) begin
                            r_out_nx   <= '0;
                            r_out_ny   <= '0;
                            r_out_nz   <= '0;
                            r_out_area <= '0;
                        end else begin
                            r_out_nx   <= r_nq[NM_W-1 -: NRM_W];
                            r_out_ny   <= r_nq[NM_W-1-NRM_W -: NRM_W];
                            r_out_nz   <= r_nq[NM_W-1-2*NRM_W -: NRM_W];
                            r_out_area <= r_nq[AREA_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_PA: begin
                    r_state <= S_PB;
                end
                S_PB: begin
                    r_pa    <= r_pq;
                    r_state <= S_PC;
                end
                S_PC: begin
                    r_pb    <= r_pq;
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    for (int i = 0; i < 3; i++) begin
                        r_e0[i] <= sat_sub(r_pb[(2-i)*POS_W +: POS_W], r_pa[(2-i)*POS_W +: POS_W]);
                        r_e1[i] <= sat_sub(r_pq[(2-i)*POS_W +: POS_W], r_pa[(2-i)*POS_W +: POS_W]);
                    end
                    r_k     <= '0;
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    // Each product is floored to Q32.16 as it is folded in.
                    r_prod <= mul_a * mul_b;
                    if (r_k != '0) begin
                        r_c[jm] <= km1[0] ? r_c[jm] - cross_term : cross_term;
                    end
                    if (r_k == 3'd6) begin
                        r_state <= S_MAG;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_MAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= mag_now[i];
                    end
                    r_m     <= max_now;
                    r_s     <= '0;
                    r_state <= (max_now == '0) ? S_IDLE : S_NORM;
                end
                S_NORM: begin
                    // Bring the largest magnitude under 31 bits.
                    if (|r_m[CRS_W-1:31]) begin
                        r_m <= r_m >> 1;
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] >> 1;
                        end
                        r_s <= r_s + 1'b1;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod <= mul_a * mul_b;
                    if (r_k != '0) begin
                        r_sum <= ((r_k == 3'd1) ? '0 : r_sum) + r_prod[SQ_W-1:0];
                    end
                    if (r_k == 3'd3) begin
                        r_state <= S_SQRT_GO;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_SQRT_GO: begin
                    r_state <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT: begin
                    if (sqrt_done) begin
                        r_root  <= sqrt_root;
                        r_state <= S_AREA;
                    end
                end
                S_AREA: begin
                    // A zero face area leaves every corner as it was.
                    r_area  <= area_sat;
                    r_state <= div_start ? S_FDIV_WAIT : S_IDLE;
                end
                S_FDIV_WAIT: begin
                    if (div_done[0]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_fn[i] <= signed_norm(div_q[i], r_c[i][CRS_W-1]);
                        end
                        r_vj    <= '0;
                        r_vaddr <= r_ia;
                        r_state <= S_V_ISSUE;
                    end
                end
                S_V_ISSUE: begin
                    r_state <= S_V_LOAD;
                end
                S_V_LOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_on[i] <= r_nq[NM_W-1-i*NRM_W -: NRM_W];
                    end
                    r_tot      <= tot_now;
                    r_wo       <= TOT_W'(old_area);
                    r_wf       <= TOT_W'(r_area);
                    r_new_area <= tot_now[TOT_W-1] ? AREA_MAX : tot_now[AREA_W-1:0];
                    r_state    <= S_V_SHIFT;
                end
                S_V_SHIFT: begin
                    // Scale both weights until the total fits 32 bits.
                    if (|r_tot[TOT_W-1:32]) begin
                        r_tot <= r_tot >> 1;
                        r_wo  <= r_wo >> 1;
                        r_wf  <= r_wf >> 1;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_V_MUL;
                    end
                end
                S_V_MUL: begin
                    r_prod <= mul_a * mul_b;
                    if (r_k != '0) begin
                        r_num[jm] <= km1[0] ? r_num[jm] + blend_term : blend_term;
                    end
                    if (r_k == 3'd6) begin
                        r_state <= S_V_DIV_GO;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_V_DIV_GO: begin
                    r_state <= S_V_DIV_WAIT;
                end
                S_V_DIV_WAIT: begin
                    // The corner is written back here; the next corner follows.
                    if (div_done[0]) begin
                        if (r_vj == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_vj    <= r_vj + 1'b1;
                            r_vaddr <= (r_vj == 2'd0) ? r_ib : r_ic;
                            r_state <= S_V_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/area_weighted_vertex_normals_core.sv
// Area-weighted vertex normal accumulator.
// Items enter through a queue-like port: push and full. Operation 0 stores a
// vertex position and clears its normal and area, 1 folds a triangle into its
// three corners, 2 reads a vertex. Only a read yields a result, presented on
// the output side while empty is low and taken with pop.
// A front queue of four items accepts and checks items; the back end works on
// one item at a time. A triangle with a nonzero face area goes through three
// position reads, six cross products through one shared multiplier, a square
// root, a divide for the face normal and, per corner, a weight scaling loop,
// six multiplies and a divide, the three components dividing in parallel.
// A degenerate triangle ends without writing any corner.
// After reset the normal and area table is cleared one entry per cycle; full
// stays high until the clearing is done.
// A result that is not popped holds the back end at the next read, while the
// front queue keeps taking items until it fills.
module area_weighted_vertex_normals_core #(
    parameter int MAX_VERTICES = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          i_operation,
    input  logic [awvn_pkg::IDX_W-1:0]          i_index_a,
    input  logic [awvn_pkg::IDX_W-1:0]          i_index_b,
    input  logic [awvn_pkg::IDX_W-1:0]          i_index_c,
    input  logic signed [awvn_pkg::POS_W-1:0]   i_coord_x,
    input  logic signed [awvn_pkg::POS_W-1:0]   i_coord_y,
    input  logic signed [awvn_pkg::POS_W-1:0]   i_coord_z,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [awvn_pkg::NRM_W-1:0]   o_normal_x,
    output logic signed [awvn_pkg::NRM_W-1:0]   o_normal_y,
    output logic signed [awvn_pkg::NRM_W-1:0]   o_normal_z,
    output logic [awvn_pkg::AREA_W-1:0]         o_total_area
);
    import awvn_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_take;
    logic clearing;
    logic out_valid;

    assign empty = !out_valid;

    awvn_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_operation (i_operation),
        .i_index_a   (i_index_a),
        .i_index_b   (i_index_b),
        .i_index_c   (i_index_c),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_coord_z   (i_coord_z),
        .i_clearing  (clearing),
        .i_take      (cmd_take),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid)
    );

    awvn_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cmd_valid  (cmd_valid),
        .o_cmd_take   (cmd_take),
        .o_clearing   (clearing),
        .i_pop        (pop),
        .o_out_valid  (out_valid),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_total_area (o_total_area)
    );

endmodule
